// ===== rtl/core/ipru_pkg.sv =====
// Shared constants and types for the integer pixel replication upscaler.
`timescale 1ns / 1ps
`default_nettype none
package ipru_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int MAX_SCALE = 100;

   localparam int ADDR_W  = $clog2(MAX_WIDTH);
   localparam int WIDTH_W = 11;
   localparam int SCALE_W = 7;
   localparam int PIXEL_W = 24;
   localparam int CSR_W   = 11;

   localparam logic [WIDTH_W-1:0] MAX_WIDTH_V = WIDTH_W'(MAX_WIDTH);
   localparam logic [SCALE_W-1:0] MAX_SCALE_V = SCALE_W'(MAX_SCALE);

   typedef enum logic {
      CSR_SCALE_FACTOR = 1'b0,
      CSR_SOURCE_WIDTH = 1'b1
   } csr_index_type;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_PULL = 1'b1
   } op_type;

   typedef struct packed {
      logic       empty;
      logic [1:0] pad;
      logic       row_end;
      logic       src_done;
   } ipru_flags_type;

endpackage
`default_nettype wire

// ===== rtl/core/ipru_line_ram.sv =====
// Simple dual-port line buffer RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module ipru_line_ram #(
   parameter int DEPTH  = 1024,
   parameter int DATA_W = 24,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/ipru_ctrl.sv =====
// Configuration registers, load and replay counters, and line buffer addressing.
`timescale 1ns / 1ps
`default_nettype none
module ipru_ctrl import ipru_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic               csr_index,
   input  wire logic [CSR_W-1:0]   csr_wdata,
   input  wire logic               accept,
   input  wire logic               op,
   input  wire logic [PIXEL_W-1:0] pixel,
   output logic                    mem_wr_en,
   output logic      [ADDR_W-1:0]  mem_wr_addr,
   output logic      [PIXEL_W-1:0] mem_wr_data,
   output logic                    mem_rd_en,
   output logic      [ADDR_W-1:0]  mem_rd_addr,
   output logic                    pull_fire,
   output ipru_flags_type          flags
);

   logic [SCALE_W-1:0] scale_ff;
   logic [WIDTH_W-1:0] width_ff;
   logic [ADDR_W-1:0]  load_col_ff, load_col_in;
   logic               held_ff, held_in;
   logic [ADDR_W-1:0]  emit_col_ff, emit_col_in;
   logic [SCALE_W-1:0] pix_rep_ff, pix_rep_in;
   logic [SCALE_W-1:0] row_rep_ff, row_rep_in;

   logic [SCALE_W-1:0] scale_eff;
   logic [WIDTH_W-1:0] width_eff;
   logic [WIDTH_W-1:0] load_nxt, emit_nxt;
   logic [SCALE_W:0]   pix_nxt, row_nxt;
   logic [3:0]         pad_prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_W'(1);
         width_ff <= WIDTH_W'(1);
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_SCALE_FACTOR: scale_ff <= csr_wdata[SCALE_W-1:0];
            CSR_SOURCE_WIDTH: width_ff <= csr_wdata[WIDTH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (scale_ff == '0) begin
         scale_eff = SCALE_W'(1);
      end else if (scale_ff > MAX_SCALE_V) begin
         scale_eff = MAX_SCALE_V;
      end else begin
         scale_eff = scale_ff;
      end
      if (width_ff == '0) begin
         width_eff = WIDTH_W'(1);
      end else if (width_ff > MAX_WIDTH_V) begin
         width_eff = MAX_WIDTH_V;
      end else begin
         width_eff = width_ff;
      end
   end

   // Pad bytes are (-3*W*S) mod 4, which equals (W*S) mod 4.
   assign pad_prod = 4'(width_eff[1:0] * scale_eff[1:0]);

   assign load_nxt = WIDTH_W'(load_col_ff) + WIDTH_W'(1);
   assign emit_nxt = WIDTH_W'(emit_col_ff) + WIDTH_W'(1);
   assign pix_nxt  = {1'b0, pix_rep_ff} + (SCALE_W+1)'(1);
   assign row_nxt  = {1'b0, row_rep_ff} + (SCALE_W+1)'(1);

   assign mem_wr_addr = load_col_ff;
   assign mem_wr_data = pixel;
   assign mem_rd_addr = emit_col_ff;

   always_comb begin
      load_col_in = load_col_ff;
      held_in     = held_ff;
      emit_col_in = emit_col_ff;
      pix_rep_in  = pix_rep_ff;
      row_rep_in  = row_rep_ff;
      mem_wr_en   = 1'b0;
      mem_rd_en   = 1'b0;
      pull_fire   = 1'b0;
      flags       = '0;

      if (accept && op_type'(op) == OP_LOAD && !held_ff) begin
         mem_wr_en = 1'b1;
         if (load_nxt >= width_eff) begin
            load_col_in = '0;
            held_in     = 1'b1;
            emit_col_in = '0;
            pix_rep_in  = '0;
            row_rep_in  = '0;
         end else begin
            load_col_in = load_nxt[ADDR_W-1:0];
         end
      end else if (accept && op_type'(op) == OP_PULL) begin
         pull_fire = 1'b1;
         if (!held_ff) begin
            flags.empty = 1'b1;
         end else begin
            mem_rd_en  = 1'b1;
            pix_rep_in = pix_nxt[SCALE_W-1:0];
            if (pix_nxt >= {1'b0, scale_eff}) begin
               pix_rep_in = '0;
               if (emit_nxt >= width_eff) begin
                  emit_col_in   = '0;
                  flags.pad     = pad_prod[1:0];
                  flags.row_end = 1'b1;
                  row_rep_in    = row_nxt[SCALE_W-1:0];
                  if (row_nxt >= {1'b0, scale_eff}) begin
                     row_rep_in     = '0;
                     held_in        = 1'b0;
                     flags.src_done = 1'b1;
                  end
               end else begin
                  emit_col_in = emit_nxt[ADDR_W-1:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_col_ff <= '0;
         held_ff     <= 1'b0;
         emit_col_ff <= '0;
         pix_rep_ff  <= '0;
         row_rep_ff  <= '0;
      end else begin
         load_col_ff <= load_col_in;
         held_ff     <= held_in;
         emit_col_ff <= emit_col_in;
         pix_rep_ff  <= pix_rep_in;
         row_rep_ff  <= row_rep_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/ipru_out.sv =====
// Read stage and output register of the result channel.
`timescale 1ns / 1ps
`default_nettype none
module ipru_out import ipru_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               pull_fire,
   input  ipru_flags_type          flags,
   input  wire logic [PIXEL_W-1:0] rd_data,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic      [7:0]         rsp_out_blue,
   output logic      [7:0]         rsp_out_green,
   output logic      [7:0]         rsp_out_red,
   output logic      [1:0]         rsp_pad_bytes,
   output logic                    rsp_row_end,
   output logic                    rsp_source_row_done,
   output logic                    rsp_empty_res
);

   logic           s1_valid_ff, s1_valid_in;
   ipru_flags_type s1_flags_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0] pix_ff;
   ipru_flags_type     out_flags_ff;
   logic               advance;

   // The read data register only changes on a new read, which happens only
   // when the read stage can move on, so it holds while the stage waits.
   assign advance      = !rsp_valid_ff || !rsp_stall;
   assign req_stall    = s1_valid_ff && !advance;
   assign s1_valid_in  = (advance || !s1_valid_ff) ? pull_fire : s1_valid_ff;
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pull_fire && (advance || !s1_valid_ff)) begin
         s1_flags_ff <= flags;
      end
      if (advance && s1_valid_ff) begin
         out_flags_ff <= s1_flags_ff;
         pix_ff       <= s1_flags_ff.empty ? '0 : rd_data;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_blue        = pix_ff[7:0];
   assign rsp_out_green       = pix_ff[15:8];
   assign rsp_out_red         = pix_ff[23:16];
   assign rsp_pad_bytes       = out_flags_ff.pad;
   assign rsp_row_end         = out_flags_ff.row_end;
   assign rsp_source_row_done = out_flags_ff.src_done;
   assign rsp_empty_res       = out_flags_ff.empty;

endmodule
`default_nettype wire

// ===== rtl/core/integer_pixel_replication_upscaler.sv =====
// Top level of the integer pixel replication upscaler.
// Usage:
// The request channel (req_valid, req_stall, req_op and the color fields)
// carries two kinds of item. A load item (op 0) writes one source pixel into
// the line buffer; after source_width loads a full row is held and further
// loads are dropped until that row has been replayed. A pull item (op 1)
// returns one result: the next output pixel, each source pixel repeated
// scale_factor times and the row repeated scale_factor times. The last pixel
// of an output row flags row_end and the pad bytes needed for a 4-byte row
// multiple; source_row_done marks the final replica. A pull with no row held
// returns a result with only empty_res set. Loads return nothing.
// A pull is read from the line buffer into the read stage when it is accepted
// and moves on into the output register once that register is free or its
// result is taken. Throughput is one item per cycle while req_stall is low.
// When rsp_stall is held the output register keeps its result, the read
// stage takes one more pull if empty, then req_stall rises until it is taken.
// Synchronous reset clears all counters, sets scale and width to one and
// empties the pipeline; the line buffer itself is not cleared.
// Configuration writes on the csr_ port take effect at the next clock edge.
`timescale 1ns / 1ps
`default_nettype none
module integer_pixel_replication_upscaler import ipru_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic             csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic             req_op,
   input  wire logic [7:0]       req_blue,
   input  wire logic [7:0]       req_green,
   input  wire logic [7:0]       req_red,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic      [7:0]       rsp_out_blue,
   output logic      [7:0]       rsp_out_green,
   output logic      [7:0]       rsp_out_red,
   output logic      [1:0]       rsp_pad_bytes,
   output logic                  rsp_row_end,
   output logic                  rsp_source_row_done,
   output logic                  rsp_empty_res
);

   logic               accept;
   logic               mem_wr_en, mem_rd_en, pull_fire;
   logic [ADDR_W-1:0]  mem_wr_addr, mem_rd_addr;
   logic [PIXEL_W-1:0] mem_wr_data, rd_data;
   ipru_flags_type     flags;

   assign accept = req_valid && !req_stall;

   // Loads and pulls never share a cycle, and a pull can only read a row once
   // the held flag set by the load that completes it is registered, so reads
   // always see the written data without forwarding.
   ipru_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .accept      (accept),
      .op          (req_op),
      .pixel       ({req_red, req_green, req_blue}),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .pull_fire   (pull_fire),
      .flags       (flags)
   );

   ipru_line_ram #(
      .DEPTH  (MAX_WIDTH),
      .DATA_W (PIXEL_W),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (rd_data)
   );

   ipru_out u_out (
      .clock               (clock),
      .reset               (reset),
      .pull_fire           (pull_fire),
      .flags               (flags),
      .rd_data             (rd_data),
      .req_stall           (req_stall),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_blue        (rsp_out_blue),
      .rsp_out_green       (rsp_out_green),
      .rsp_out_red         (rsp_out_red),
      .rsp_pad_bytes       (rsp_pad_bytes),
      .rsp_row_end         (rsp_row_end),
      .rsp_source_row_done (rsp_source_row_done),
      .rsp_empty_res       (rsp_empty_res)
   );

endmodule
`default_nettype wire

// ===== rtl/core/ipru_checker.sv =====
// Port-level checks for the upscaler and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none
module ipru_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_out_blue,
   input wire logic [7:0] rsp_out_green,
   input wire logic [7:0] rsp_out_red,
   input wire logic [1:0] rsp_pad_bytes,
   input wire logic       rsp_row_end,
   input wire logic       rsp_source_row_done,
   input wire logic       rsp_empty_res
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_blue)
         && $stable(rsp_out_green) && $stable(rsp_out_red)
         && $stable(rsp_row_end) && $stable(rsp_empty_res))
      else $error("stalled result changed");

   a_empty_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |-> rsp_out_blue == 8'd0
         && rsp_out_green == 8'd0 && rsp_out_red == 8'd0
         && rsp_pad_bytes == 2'd0 && !rsp_row_end && !rsp_source_row_done)
      else $error("empty result carries data");

   a_done_at_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_source_row_done |-> rsp_row_end)
      else $error("source row done off a row end");

   a_pad_at_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_row_end |-> rsp_pad_bytes == 2'd0)
      else $error("pad bytes inside a row");

endmodule

bind integer_pixel_replication_upscaler ipru_checker u_ipru_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_out_blue        (rsp_out_blue),
   .rsp_out_green       (rsp_out_green),
   .rsp_out_red         (rsp_out_red),
   .rsp_pad_bytes       (rsp_pad_bytes),
   .rsp_row_end         (rsp_row_end),
   .rsp_source_row_done (rsp_source_row_done),
   .rsp_empty_res       (rsp_empty_res)
);
`default_nettype wire
